[hdl/evd_pkg.sv]
// Shared types, constants and helper functions for the EBML variable-length
// integer decoder. Used by evd_finish and ebml_vint_decoder; depends on nothing.
`default_nettype none

package evd_pkg;

   // Longest integer accepted for the size kinds and for element IDs.
   localparam int unsigned MaxSizeBytes = 8;
   localparam int unsigned MaxIdBytes   = 4;

   // Kind codes as they arrive on the input channel.
   localparam logic [1:0] KIND_SIZE     = 2'd0;
   localparam logic [1:0] KIND_SIGNED   = 2'd1;
   localparam logic [1:0] KIND_ID       = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // One input transaction.
   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] kind;
   } req_payload_type;

   // One result transaction.
   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  length;
      logic        is_unknown;
      logic        bad_lead;
   } rsp_payload_type;

   // A completed integer handed from the byte collector to the finishing logic.
   typedef struct packed {
      logic [63:0] raw;
      logic [3:0]  len;
      logic [1:0]  kind;
      logic        bad;
   } fin_job_type;

   // Length coded by a first byte: leading zeros plus one, 9 when there is no marker.
   function automatic logic [3:0] lead_len(input logic [7:0] b);
      logic [3:0] len;
      begin
         priority if (b[7]) len = 4'd1;
         else if (b[6])     len = 4'd2;
         else if (b[5])     len = 4'd3;
         else if (b[4])     len = 4'd4;
         else if (b[3])     len = 4'd5;
         else if (b[2])     len = 4'd6;
         else if (b[1])     len = 4'd7;
         else if (b[0])     len = 4'd8;
         else               len = 4'd9;
         return len;
      end
   endfunction

   // Payload mask of 7 bits per byte; lengths outside 1 to 8 count as one byte.
   function automatic logic [63:0] payload_mask(input logic [3:0] len);
      logic [63:0] mask;
      begin
         unique case (len)
            4'd2:    mask = 64'h0000_0000_0000_3FFF;
            4'd3:    mask = 64'h0000_0000_001F_FFFF;
            4'd4:    mask = 64'h0000_0000_0FFF_FFFF;
            4'd5:    mask = 64'h0000_0007_FFFF_FFFF;
            4'd6:    mask = 64'h0000_03FF_FFFF_FFFF;
            4'd7:    mask = 64'h0001_FFFF_FFFF_FFFF;
            4'd8:    mask = 64'h00FF_FFFF_FFFF_FFFF;
            default: mask = 64'h0000_0000_0000_007F;
         endcase
         return mask;
      end
   endfunction

endpackage

`default_nettype wire

[hdl/ebml_vint_decoder.sv]
// Top level of the EBML variable-length integer decoder.
// Depends on evd_pkg and evd_finish.
`default_nettype none

// The decoder takes one stream byte per cycle and keeps taking bytes while a
// result waits on the output, as long as the job stage is empty. The first byte
// of an integer sets its length from the position of the marker bit and samples
// the kind; the byte that completes the integer yields one result transaction,
// held first in the job register after the byte collector, then in the result
// register after the finishing logic (a 64-bit subtract and compare). A first
// byte without a marker inside the allowed length yields an error result
// through the same registers, and the decoder stays ready for a new integer.
// Only backpressure on the result channel slows the input, and a byte is
// taken whenever the job stage can move.
module ebml_vint_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  evd_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output evd_pkg::rsp_payload_type  rsp_payload
);

   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [3:0]  total_len_ff, total_len_in;
   logic [1:0]  cur_kind_ff, cur_kind_in;
   logic [63:0] acc_ff, acc_in;

   logic                     job_valid_ff, job_valid_in;
   evd_pkg::fin_job_type     job_ff, job_in;
   logic                     job_load;

   logic                     rsp_valid_ff, rsp_valid_in;
   evd_pkg::rsp_payload_type rsp_data_ff;
   evd_pkg::rsp_payload_type fin_rsp;

   logic        rsp_open;
   logic        job_open;
   logic        req_fire;
   logic [1:0]  kind_norm;
   logic [3:0]  first_len;
   logic [3:0]  max_len;
   logic [63:0] shifted;

   // Handshake: each stage moves when the one after it is empty or drains.
   assign rsp_open  = !rsp_valid_ff || rsp_ready;
   assign job_open  = !job_valid_ff || rsp_open;
   assign req_ready = job_open;
   assign req_fire  = req_valid && req_ready;

   // First-byte decode and continuation shift.
   assign kind_norm = (req_payload.kind == evd_pkg::KIND_RESERVED) ?
                      evd_pkg::KIND_SIZE : req_payload.kind;
   assign first_len = evd_pkg::lead_len(req_payload.data_byte);
   assign max_len   = (kind_norm == evd_pkg::KIND_ID) ?
                      4'(evd_pkg::MaxIdBytes) : 4'(evd_pkg::MaxSizeBytes);
   assign shifted   = {acc_ff[55:0], req_payload.data_byte};

   // Byte collector: next state and the job for a completed integer.
   always_comb begin
      bytes_left_in = bytes_left_ff;
      total_len_in  = total_len_ff;
      cur_kind_in   = cur_kind_ff;
      acc_in        = acc_ff;
      job_load      = 1'b0;
      job_in        = job_ff;
      if (req_fire) begin
         if (bytes_left_ff == 3'd0) begin
            if (first_len > max_len) begin
               job_load    = 1'b1;
               job_in.raw  = 64'd0;
               job_in.len  = 4'd0;
               job_in.kind = kind_norm;
               job_in.bad  = 1'b1;
            end else begin
               cur_kind_in  = kind_norm;
               total_len_in = first_len;
               acc_in       = {56'd0, req_payload.data_byte};
               if (first_len == 4'd1) begin
                  job_load    = 1'b1;
                  job_in.raw  = {56'd0, req_payload.data_byte};
                  job_in.len  = first_len;
                  job_in.kind = kind_norm;
                  job_in.bad  = 1'b0;
               end else begin
                  bytes_left_in = 3'(first_len - 4'd1);
               end
            end
         end else begin
            acc_in        = shifted;
            bytes_left_in = bytes_left_ff - 3'd1;
            if (bytes_left_ff == 3'd1) begin
               job_load    = 1'b1;
               job_in.raw  = shifted;
               job_in.len  = total_len_ff;
               job_in.kind = cur_kind_ff;
               job_in.bad  = 1'b0;
            end
         end
      end
   end

   // Valid bits of the job and result stages.
   assign job_valid_in = job_open ? job_load : job_valid_ff;
   assign rsp_valid_in = rsp_open ? job_valid_ff : rsp_valid_ff;

   evd_finish u_finish (
      .job (job_ff),
      .rsp (fin_rsp)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 3'd0;
         total_len_ff  <= 4'd0;
         cur_kind_ff   <= evd_pkg::KIND_SIZE;
         job_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         total_len_ff  <= total_len_in;
         cur_kind_ff   <= cur_kind_in;
         job_valid_ff  <= job_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (job_open && job_load) begin
         job_ff <= job_in;
      end
      if (rsp_open && job_valid_ff) begin
         rsp_data_ff <= fin_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // While an integer is open, fewer bytes remain than its total length.
   a_bytes_left_bound : assert property (@(posedge clock) disable iff (reset)
      (bytes_left_ff != 3'd0) |-> ({1'b0, bytes_left_ff} < total_len_ff))
      else $error("bytes remaining not below integer length");

   // The byte that closes an integer always puts a job into the job stage.
   a_close_loads_job : assert property (@(posedge clock) disable iff (reset)
      (req_fire && bytes_left_ff == 3'd1) |=> job_valid_ff)
      else $error("completed integer did not reach the job stage");

   // An error result carries no length and no unknown flag.
   a_bad_result_form : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.bad_lead) |->
      (rsp_data_ff.length == 4'd0 && !rsp_data_ff.is_unknown))
      else $error("error result with nonzero length or unknown flag");

endmodule

`default_nettype wire

[hdl/evd_finish.sv]
// Finishing logic of the EBML variable-length integer decoder: marker
// stripping, unknown-size detection and signed bias. Depends on evd_pkg.
`default_nettype none

module evd_finish (
   input  evd_pkg::fin_job_type     job,
   output evd_pkg::rsp_payload_type rsp
);

   logic [63:0] mask;
   logic [63:0] half;
   logic [63:0] payload;
   logic        all_set;
   logic [63:0] biased;

   // Payload bits and the half range for the coded length.
   assign mask    = evd_pkg::payload_mask(job.len);
   assign half    = {1'b0, mask[63:1]};
   assign payload = job.raw & mask;
   assign all_set = (payload == mask);
   assign biased  = payload - half;

   // Select the result by kind; all ones minus the half range is its inverse.
   always_comb begin
      rsp.value      = payload;
      rsp.length     = job.len;
      rsp.is_unknown = 1'b0;
      rsp.bad_lead   = 1'b0;
      if (job.bad) begin
         rsp.value    = (job.kind == evd_pkg::KIND_SIZE) ? evd_pkg::ALL_ONES : 64'd0;
         rsp.length   = 4'd0;
         rsp.bad_lead = 1'b1;
      end else if (job.kind == evd_pkg::KIND_ID) begin
         rsp.value = job.raw;
      end else if (job.kind == evd_pkg::KIND_SIGNED) begin
         rsp.value      = all_set ? ~half : biased;
         rsp.is_unknown = all_set;
      end else begin
         rsp.value      = all_set ? evd_pkg::ALL_ONES : payload;
         rsp.is_unknown = all_set;
      end
   end

endmodule

`default_nettype wire
